// ===== hw/rtl/y86_instruction_executor_defines.svh =====
// Assertion macros for the instruction executor.
`ifndef Y86_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define Y86_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Clocked on clk, off while rst_n is low.
`define Y86IE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked during reset.
`define Y86IE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/y86ie_pkg.sv =====
// ----------------------------------------------------------------------------
// y86ie_pkg
// Shared constants, codes, state and command types of the instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package y86ie_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int NREG      = 16;
  localparam int CNT_W     = 4;
  localparam int IBUF_N    = 10;

  localparam logic [CNT_W-1:0] FETCH_LAST = CNT_W'(IBUF_N);
  localparam logic [CNT_W-1:0] WR_LAST    = 4'd7;
  localparam logic [CNT_W-1:0] RD_LAST    = 4'd8;
  localparam logic [CNT_W-1:0] DUMP_LAST  = 4'd14;
  localparam logic [3:0]       REG_SP     = 4'd4;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;

  localparam logic [2:0] KIND_DONE     = 3'd0;
  localparam logic [2:0] KIND_HALTED   = 3'd1;
  localparam logic [2:0] KIND_DUMP_REG = 3'd2;
  localparam logic [2:0] KIND_DUMP_MEM = 3'd3;
  localparam logic [2:0] KIND_BAD_OP   = 3'd4;
  localparam logic [2:0] KIND_IDLE     = 3'd5;

  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_NOP   = 4'h1;
  localparam logic [3:0] OP_CMOV  = 4'h2;
  localparam logic [3:0] OP_IRMOV = 4'h3;
  localparam logic [3:0] OP_RMMOV = 4'h4;
  localparam logic [3:0] OP_MRMOV = 4'h5;
  localparam logic [3:0] OP_ALU   = 4'h6;
  localparam logic [3:0] OP_JXX   = 4'h7;
  localparam logic [3:0] OP_CALL  = 4'h8;
  localparam logic [3:0] OP_RET   = 4'h9;
  localparam logic [3:0] OP_PUSH  = 4'hA;
  localparam logic [3:0] OP_POP   = 4'hB;
  localparam logic [3:0] OP_DUMPA = 4'hC;
  localparam logic [3:0] OP_DUMPR = 4'hD;
  localparam logic [3:0] OP_DUMPM = 4'hE;
  localparam logic [3:0] OP_BAD   = 4'hF;

  localparam logic [3:0] FN_ADD = 4'h0;
  localparam logic [3:0] FN_SUB = 4'h1;
  localparam logic [3:0] FN_AND = 4'h2;
  localparam logic [3:0] FN_XOR = 4'h3;

  localparam logic [3:0] CC_ALWAYS = 4'h0;
  localparam logic [3:0] CC_LE     = 4'h1;
  localparam logic [3:0] CC_L      = 4'h2;
  localparam logic [3:0] CC_E      = 4'h3;
  localparam logic [3:0] CC_NE     = 4'h4;
  localparam logic [3:0] CC_GE     = 4'h5;
  localparam logic [3:0] CC_G      = 4'h6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_RA, ST_RB, ST_RS, ST_CAPS, ST_EX,
    ST_MWR, ST_MRD, ST_WBSP, ST_WB, ST_RESP, ST_DRD, ST_DOUT
  } state_t;

  typedef enum logic [1:0] {RSEL_A, RSEL_B, RSEL_SP, RSEL_CNT} rsel_t;

  typedef struct packed {
    logic  take;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  fetch;
    logic  rf_rd;
    rsel_t rsel;
    logic  cap_a;
    logic  cap_b;
    logic  cap_s;
    logic  exec;
    logic  mem_wr;
    logic  mem_rd;
    logic  wb_sp;
    logic  wb_main;
    logic  out_load;
    logic  out_dump;
  } ctl_cmd_t;

  typedef struct packed {
    logic             halted;
    logic [3:0]       op;
    logic [CNT_W-1:0] cnt;
    logic             out_free;
  } dp_stat_t;

  function automatic logic op_writes_mem(input logic [3:0] op);
    return op inside {OP_RMMOV, OP_CALL, OP_PUSH};
  endfunction

  function automatic logic op_reads_mem(input logic [3:0] op);
    return op inside {OP_MRMOV, OP_RET, OP_POP, OP_DUMPM};
  endfunction

  // Unknown condition codes are never taken.
  function automatic logic cond_ok(input logic [3:0] fn, input logic zf, input logic sf);
    logic r;
    case (fn)
      CC_ALWAYS: r = 1'b1;
      CC_LE:     r = sf | zf;
      CC_L:      r = sf;
      CC_E:      r = zf;
      CC_NE:     r = ~zf;
      CC_GE:     r = ~sf;
      CC_G:      r = ~sf & ~zf;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/y86ie_ram.sv =====
// ----------------------------------------------------------------------------
// y86ie_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module y86ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/y86ie_ctrl.sv =====
// ----------------------------------------------------------------------------
// y86ie_ctrl
// Sequencer: fetch, register reads, execute, memory access, write back, reply or register dump.
// ----------------------------------------------------------------------------
`default_nettype none

module y86ie_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_action,
  output logic                     in_ready,
  input  wire y86ie_pkg::dp_stat_t st,
  output y86ie_pkg::ctl_cmd_t      cmd
);
  import y86ie_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_action == ACT_EXEC && !st.halted) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_FETCH;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.cnt == FETCH_LAST) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_RA;
        end
      end
      ST_RA: begin
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RSEL_A;
        state_nxt = ST_RB;
      end
      ST_RB: begin
        cmd.cap_a = 1'b1;
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RSEL_B;
        state_nxt = ST_RS;
      end
      ST_RS: begin
        cmd.cap_b = 1'b1;
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RSEL_SP;
        state_nxt = ST_CAPS;
      end
      ST_CAPS: begin
        cmd.cap_s = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (op_writes_mem(st.op)) begin
          state_nxt = ST_MWR;
        end else if (op_reads_mem(st.op)) begin
          state_nxt = ST_MRD;
        end else begin
          state_nxt = ST_WBSP;
        end
      end
      ST_MWR: begin
        cmd.mem_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.cnt == WR_LAST) begin
          state_nxt = ST_WBSP;
        end
      end
      ST_MRD: begin
        cmd.mem_rd  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.cnt == RD_LAST) begin
          state_nxt = ST_WBSP;
        end
      end
      ST_WBSP: begin
        cmd.wb_sp = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb_main = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = (st.op == OP_DUMPA) ? ST_DRD : ST_RESP;
      end
      ST_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DRD: begin
        cmd.rf_rd = 1'b1;
        cmd.rsel  = RSEL_CNT;
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        // hold the read data until the output register frees up
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_dump = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_nxt    = (st.cnt == DUMP_LAST) ? ST_IDLE : ST_DRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/y86ie_dpath.sv =====
// ----------------------------------------------------------------------------
// y86ie_dpath
// Architectural state, data memory, register file, ALU and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module y86ie_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          in_action,
  input  wire logic [15:0]         in_address,
  input  wire logic [7:0]          in_data_byte,
  input  wire y86ie_pkg::ctl_cmd_t cmd,
  output y86ie_pkg::dp_stat_t      st,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_kind,
  output logic [15:0]              out_pc,
  output logic [3:0]               out_reg_index,
  output logic signed [63:0]       out_value,
  output logic [15:0]              out_mem_address,
  output logic                     out_last
);
  import y86ie_pkg::*;

  logic [15:0]       pc_r;
  logic              zf_r, sf_r, halted_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        ibuf_r [IBUF_N];
  logic [63:0]       a_r, b_r, s_r, alu_r, wdat_r, rdat_r;
  logic [MEM_AW-1:0] ea_r;
  logic [2:0]        kind_r;
  logic [3:0]        ridx_r;
  logic [63:0]       val_r;
  logic [15:0]       maddr_r;
  logic [NREG-1:0]   rf_vld_r;
  logic              rf_vld_q_r;

  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic [15:0]       out_pc_r;
  logic [3:0]        out_ridx_r;
  logic [63:0]       out_val_r;
  logic [15:0]       out_maddr_r;
  logic              out_last_r;

  logic [3:0]  op, fn, ra, rb;
  logic [63:0] c8, c9;
  logic        cond;
  logic [15:0] pc_new;

  assign op = ibuf_r[0][7:4];
  assign fn = ibuf_r[0][3:0];
  assign ra = ibuf_r[1][7:4];
  assign rb = ibuf_r[1][3:0];
  assign c8 = {ibuf_r[8], ibuf_r[7], ibuf_r[6], ibuf_r[5],
               ibuf_r[4], ibuf_r[3], ibuf_r[2], ibuf_r[1]};
  assign c9 = {ibuf_r[9], ibuf_r[8], ibuf_r[7], ibuf_r[6],
               ibuf_r[5], ibuf_r[4], ibuf_r[3], ibuf_r[2]};
  assign cond = cond_ok(fn, zf_r, sf_r);

  // ---------------- data memory
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_q;

  always_comb begin
    mem_we    = cmd.take && (in_action == ACT_LOAD);
    mem_waddr = MEM_AW'(in_address);
    mem_wdata = in_data_byte;
    if (cmd.mem_wr) begin
      mem_we    = 1'b1;
      mem_waddr = ea_r + MEM_AW'(cnt_r);
      mem_wdata = 8'(wdat_r >> {cnt_r[2:0], 3'b000});
    end
    mem_re    = 1'b0;
    mem_raddr = MEM_AW'(32'(pc_r) + 32'(cnt_r));
    if (cmd.fetch) begin
      mem_re = (cnt_r < FETCH_LAST);
    end else if (cmd.mem_rd) begin
      mem_re    = (cnt_r < RD_LAST);
      mem_raddr = ea_r + MEM_AW'(cnt_r);
    end
  end

  y86ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // ---------------- register file
  logic        rf_we;
  logic [3:0]  rf_waddr, rf_raddr;
  logic [63:0] rf_wdata, rf_q, rf_val;

  always_comb begin
    case (cmd.rsel)
      RSEL_A:   rf_raddr = ra;
      RSEL_B:   rf_raddr = rb;
      RSEL_SP:  rf_raddr = REG_SP;
      RSEL_CNT: rf_raddr = cnt_r;
      default:  rf_raddr = ra;
    endcase
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rb;
    rf_wdata = a_r;
    if (cmd.wb_sp) begin
      rf_waddr = REG_SP;
      case (op)
        OP_CALL, OP_PUSH: begin
          rf_we    = 1'b1;
          rf_wdata = s_r - 64'd8;
        end
        OP_RET, OP_POP: begin
          rf_we    = 1'b1;
          rf_wdata = s_r + 64'd8;
        end
        default: rf_we = 1'b0;
      endcase
    end else if (cmd.wb_main) begin
      case (op)
        OP_CMOV: rf_we = cond;
        OP_IRMOV: begin
          rf_we    = 1'b1;
          rf_wdata = c9;
        end
        OP_MRMOV, OP_POP: begin
          rf_we    = 1'b1;
          rf_waddr = ra;
          rf_wdata = rdat_r;
        end
        OP_ALU: begin
          rf_we    = fn inside {FN_ADD, FN_SUB, FN_AND, FN_XOR};
          rf_wdata = alu_r;
        end
        default: rf_we = 1'b0;
      endcase
    end
  end

  y86ie_ram #(.WIDTH(64), .DEPTH(NREG)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (cmd.rf_rd),
    .raddr (rf_raddr),
    .rdata (rf_q)
  );

  // never-written registers read as zero
  assign rf_val = rf_vld_q_r ? rf_q : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rf_rd) begin
      rf_vld_q_r <= rf_vld_r[rf_raddr];
    end
  end

  // ---------------- execute
  logic [63:0] add_x, add_y, alu_nxt, wdat_nxt;

  always_comb begin
    add_x = b_r;
    add_y = c9;
    case (op)
      OP_DUMPM: add_x = a_r;
      OP_CALL, OP_PUSH: begin
        add_x = s_r;
        add_y = -64'd8;
      end
      OP_RET, OP_POP: begin
        add_x = s_r;
        add_y = 64'd0;
      end
      default: add_x = b_r;
    endcase
  end

  always_comb begin
    case (fn)
      FN_ADD:  alu_nxt = b_r + a_r;
      FN_SUB:  alu_nxt = b_r - a_r;
      FN_AND:  alu_nxt = b_r & a_r;
      FN_XOR:  alu_nxt = b_r ^ a_r;
      default: alu_nxt = b_r;
    endcase
  end

  assign wdat_nxt = (op == OP_CALL) ? 64'(pc_r + 16'd9) : a_r;

  always_comb begin
    case (op)
      OP_HALT:                                     pc_new = pc_r;
      OP_CMOV, OP_ALU, OP_PUSH, OP_POP, OP_DUMPR:  pc_new = pc_r + 16'd2;
      OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_DUMPM:      pc_new = pc_r + 16'd10;
      OP_JXX:   pc_new = cond ? c8[15:0] : pc_r + 16'd9;
      OP_CALL:  pc_new = c8[15:0];
      OP_RET:   pc_new = rdat_r[15:0];
      default:  pc_new = pc_r + 16'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    for (int i = 0; i < IBUF_N; i++) begin
      if (cmd.fetch && cnt_r == CNT_W'(i + 1)) begin
        ibuf_r[i] <= mem_q;
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (cmd.mem_rd && cnt_r == CNT_W'(i + 1)) begin
        rdat_r[8*i +: 8] <= mem_q;
      end
    end
    if (cmd.cap_a) a_r <= rf_val;
    if (cmd.cap_b) b_r <= rf_val;
    if (cmd.cap_s) s_r <= rf_val;
    if (cmd.exec) begin
      ea_r   <= MEM_AW'(add_x + add_y);
      alu_r  <= alu_nxt;
      wdat_r <= wdat_nxt;
    end
  end

  // ---------------- architectural state and reply fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      zf_r     <= 1'b0;
      sf_r     <= 1'b0;
      halted_r <= 1'b1;
    end else if (cmd.take) begin
      if (in_action == ACT_START) begin
        pc_r     <= in_address;
        halted_r <= 1'b0;
      end
    end else if (cmd.wb_main) begin
      pc_r <= pc_new;
      if (op == OP_HALT) halted_r <= 1'b1;
      if (op == OP_ALU) begin
        zf_r <= (alu_r == 64'd0);
        sf_r <= alu_r[63];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r  <= (in_action == ACT_EXEC && halted_r) ? KIND_IDLE : KIND_DONE;
      ridx_r  <= '0;
      val_r   <= '0;
      maddr_r <= '0;
    end else if (cmd.wb_main) begin
      case (op)
        OP_HALT: kind_r <= KIND_HALTED;
        OP_DUMPA: kind_r <= KIND_DUMP_REG;
        OP_DUMPR: begin
          kind_r <= KIND_DUMP_REG;
          ridx_r <= ra;
          val_r  <= a_r;
        end
        OP_DUMPM: begin
          kind_r  <= KIND_DUMP_MEM;
          val_r   <= rdat_r;
          maddr_r <= 16'(ea_r);
        end
        OP_BAD:  kind_r <= KIND_BAD_OP;
        default: kind_r <= KIND_DONE;
      endcase
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pc_r <= pc_r;
      if (cmd.out_dump) begin
        out_kind_r  <= KIND_DUMP_REG;
        out_ridx_r  <= cnt_r;
        out_val_r   <= rf_val;
        out_maddr_r <= '0;
        out_last_r  <= (cnt_r == DUMP_LAST);
      end else begin
        out_kind_r  <= kind_r;
        out_ridx_r  <= ridx_r;
        out_val_r   <= val_r;
        out_maddr_r <= maddr_r;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_pc          = out_pc_r;
  assign out_reg_index   = out_ridx_r;
  assign out_value       = out_val_r;
  assign out_mem_address = out_maddr_r;
  assign out_last        = out_last_r;

  assign st.halted   = halted_r;
  assign st.op       = op;
  assign st.cnt      = cnt_r;
  assign st.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/y86_instruction_executor.sv =====
// One item at a time: a load or start beat goes from idle straight to its
// reply; an executed instruction's time is set by the single byte-wide
// data memory port (10 instruction-byte reads, then up to 8 data byte
// reads or writes) and the one-port register file (three reads); a
// register dump-all adds a read and a reply per register. Replies wait
// in an output register, so a stalled consumer only delays the next reply.
// ----------------------------------------------------------------------------
// y86_instruction_executor
// Y86-64 style core: controller plus datapath, one reply beat per result.
// ----------------------------------------------------------------------------
`default_nettype none

module y86_instruction_executor (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [15:0]        in_address,
  input  wire logic [7:0]         in_data_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic [15:0]             out_pc,
  output logic [3:0]              out_reg_index,
  output logic signed [63:0]      out_value,
  output logic [15:0]             out_mem_address,
  output logic                    out_last
);
  import y86ie_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;

  y86ie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  y86ie_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_address      (in_address),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_pc          (out_pc),
    .out_reg_index   (out_reg_index),
    .out_value       (out_value),
    .out_mem_address (out_mem_address),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/y86ie_checker.sv =====
// ----------------------------------------------------------------------------
// y86ie_checker
// Port-level checks for the instruction executor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "y86_instruction_executor_defines.svh"

module y86ie_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [15:0] out_pc,
  input wire logic        out_last
);
  import y86ie_pkg::*;

  `Y86IE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pc), "reply beat dropped or changed while stalled")
  `Y86IE_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while one is in work")
  `Y86IE_ASSERT(a_last, out_valid && out_kind != KIND_DUMP_REG |-> out_last, "only register dumps may span beats")
  `Y86IE_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "reply valid right after reset")

endmodule

bind y86_instruction_executor y86ie_checker u_y86ie_checker (.*);

`default_nettype wire
